// ----- sv/hed_pkg.sv -----
package hed_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] RegEscapeChar     = 3'd0;
  localparam logic [2:0] RegFieldSep       = 3'd1;
  localparam logic [2:0] RegComponentSep   = 3'd2;
  localparam logic [2:0] RegSubcomponentSep = 3'd3;
  localparam logic [2:0] RegRepeatSep      = 3'd4;

  localparam logic [7:0] CharE         = 8'h45;
  localparam logic [7:0] CharF         = 8'h46;
  localparam logic [7:0] CharR         = 8'h52;
  localparam logic [7:0] CharS         = 8'h53;
  localparam logic [7:0] CharT         = 8'h54;
  localparam logic [7:0] CharX         = 8'h58;
  localparam logic [7:0] CharBackslash = 8'h5c;

  typedef enum logic [5:0] {
    PhNormal = 6'b000001,
    PhEscape = 6'b000010,
    PhSkip   = 6'b000100,
    PhHexHi  = 6'b001000,
    PhHexLo  = 6'b010000,
    PhDead   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       token_done;
  } out_t;

  typedef struct packed {
    logic [7:0] escape_char;
    logic [7:0] field_sep;
    logic [7:0] component_sep;
    logic [7:0] subcomponent_sep;
    logic [7:0] repeat_sep;
  } cfg_t;

  // Returns {is_hex, digit value}.
  function automatic logic [4:0] hex_value(logic [7:0] b);
    logic [4:0] res;
    res = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      res = {1'b1, b[3:0]};
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      // Letters a-f and A-F have low nibbles 1 to 6.
      res = {1'b1, b[3:0] + 4'd9};
    end
    return res;
  endfunction

endpackage

// ----- sv/hl7_escape_decoder_core.sv -----
// Escape sequence decoder for the bytes of one token.
// Raw bytes enter on the input channel (in_valid_i / in_ready_o) one per
// transaction, with last_byte set on the final byte of each token. Every input
// transaction yields exactly one result transaction on the output channel
// (out_valid_o / out_ready_i); its out_valid field tells whether it carries
// a decoded byte, and token_done repeats last_byte.
// Separator and escape bytes are written through the configuration port
// (cfg_we_i, cfg_idx_i, cfg_data_i); the user must write them only while no
// transaction is in flight, which the block itself does not enforce. The byte
// is captured in an input register, decoded by one level of logic against
// the phase register and held in an output register. Throughput is one byte
// per clock unless the receiver stalls; the phase register steps with each byte.
// When the receiver stalls, the output register holds its result and the
// input register holds the next byte; input ready drops once both are full.
// Reset restores the default delimiters, returns the decoder to its normal
// phase and empties both registers.
module hl7_escape_decoder_core import hed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o
);

  cfg_t cfg;
  in_t  in_q;
  logic in_vld_q;
  out_t res_q, res;
  logic res_vld_q;
  logic advance;

  hed_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // The held byte moves into the result register when that register is empty or its result is being taken.
  assign advance    = in_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  hed_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

endmodule

// ----- sv/hed_cfg_regs.sv -----
module hed_cfg_regs import hed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       we_i,
  input  logic [2:0] idx_i,
  input  logic [7:0] data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        RegEscapeChar:      cfg_d.escape_char      = data_i;
        RegFieldSep:        cfg_d.field_sep        = data_i;
        RegComponentSep:    cfg_d.component_sep    = data_i;
        RegSubcomponentSep: cfg_d.subcomponent_sep = data_i;
        RegRepeatSep:       cfg_d.repeat_sep       = data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.escape_char      <= 8'd92;
      cfg_q.field_sep        <= 8'd124;
      cfg_q.component_sep    <= 8'd94;
      cfg_q.subcomponent_sep <= 8'd38;
      cfg_q.repeat_sep       <= 8'd126;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/hed_decode.sv -----
module hed_decode import hed_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  in_t  item_i,
  input  cfg_t cfg_i,
  output out_t result_o
);

  phase_e     phase_q, phase_d;
  logic [3:0] nibble_q, nibble_d;
  logic [4:0] hex;
  logic       valid;
  logic [7:0] ob;

  assign hex = hex_value(item_i.in_byte);

  always_comb begin
    phase_d  = phase_q;
    nibble_d = nibble_q;
    valid    = 1'b0;
    ob       = 8'd0;
    case (phase_q)
      PhEscape: begin
        phase_d = PhSkip;
        case (item_i.in_byte)
          CharE: begin valid = 1'b1; ob = cfg_i.escape_char; end
          CharF: begin valid = 1'b1; ob = cfg_i.field_sep; end
          CharR: begin valid = 1'b1; ob = cfg_i.repeat_sep; end
          CharS: begin valid = 1'b1; ob = cfg_i.component_sep; end
          CharT: begin valid = 1'b1; ob = cfg_i.subcomponent_sep; end
          CharX: phase_d = PhHexHi;
          default: phase_d = PhNormal;
        endcase
      end
      PhSkip: phase_d = PhNormal;
      PhHexHi: begin
        // A literal backslash ends hex mode, whatever the escape byte is; other non-hex bytes go dead.
        if (item_i.in_byte == CharBackslash) begin
          phase_d = PhNormal;
        end else if (hex[4]) begin
          nibble_d = hex[3:0];
          phase_d  = PhHexLo;
        end else begin
          phase_d = PhDead;
        end
      end
      PhHexLo: begin
        if (hex[4]) begin
          valid    = 1'b1;
          ob       = {nibble_q, hex[3:0]};
          nibble_d = 4'd0;
          phase_d  = PhHexHi;
        end else begin
          phase_d = PhDead;
        end
      end
      PhDead: phase_d = PhDead;
      default: begin
        if (item_i.in_byte == cfg_i.escape_char) begin
          phase_d = PhEscape;
        end else begin
          valid   = 1'b1;
          ob      = item_i.in_byte;
          phase_d = PhNormal;
        end
      end
    endcase
    if (item_i.last_byte) begin
      phase_d  = PhNormal;
      nibble_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhNormal;
      nibble_q <= 4'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      nibble_q <= nibble_d;
    end
  end

  assign result_o.out_valid  = valid;
  assign result_o.out_byte   = ob;
  assign result_o.token_done = item_i.last_byte;

endmodule
